FILE: rtl/assert_macros.svh
// Assertion helpers for the tokenizer's checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, with reset masking the check.
`define CLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, with reset masking the check.
`define CLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

FILE: rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, character codes and helpers for the command line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

    // Default sizes for the top level.
    localparam int MAX_TOKENS_DEF = 16;
    localparam int MAX_LINE_DEF   = 1024;

    // Depth of the queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LX     = 8'h78;

    // Saturation limits.
    localparam logic [30:0] DEC_MAX = 31'h7FFF_FFFF;
    localparam logic [10:0] LEN_MAX = 11'h7FF;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_STRING = 2'd0,
        KIND_HEX    = 2'd1,
        KIND_DEC    = 2'd2,
        KIND_EOL    = 2'd3
    } t_kind;

    // Scanner modes.
    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_WORD   = 2'd1,
        SCAN_QUOTED = 2'd2
    } t_scan;

    // Classification flags gathered while a token is scanned.
    typedef struct packed {
        logic digits;
        logic zero0;
        logic x1;
        logic hrun;
        logic hsat;
        logic dsat;
    } t_flags;

    // One scanned byte's results: an optional token and an optional end marker.
    typedef struct packed {
        logic        tok_valid;
        t_kind       kind;
        logic [63:0] value;
        logic [9:0]  start;
        logic [10:0] len;
        logic [4:0]  index;
        logic        sat;
        logic        eol_valid;
        logic [4:0]  eol_count;
        logic        too_many;
    } t_step_rec;

    function automatic logic is_delim(input logic [7:0] c);
        is_delim = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        is_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = is_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
                 ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Value of a hex digit; only meaningful where is_hex holds.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_digit(c)) begin
            d = c - CH_ZERO;
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            d = c - CH_LA + 8'd10;
        end else begin
            d = c - CH_UA + 8'd10;
        end
        hex_val = d[3:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// Byte scanner: splits the line into tokens, accumulates the numeric values,
// classifies finished tokens and pushes one record per producing byte.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_front #(
    parameter int MAX_TOKENS = 16,
    parameter int MAX_LINE   = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_char_in,
    input  logic                i_last,
    output logic                o_stall,
    input  logic                i_full,
    output logic                o_push,
    output clt_pkg::t_step_rec  o_rec
);
    import clt_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE);
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TOKENS);

    // Scanner state.
    t_scan             r_mode, n_mode;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_count;
    logic [POS_W-1:0]  r_start;
    logic [10:0]       r_len;
    logic [63:0]       r_hex;
    logic [30:0]       r_dec;
    t_flags            r_flags;
    logic              r_dropped;

    logic accept;
    logic c_nul, c_quote, c_delim, end_in, is_end;
    logic do_add, do_begin_quote, do_finish, fin_added;

    // Accumulator base: fresh for a token that begins on this byte.
    logic [10:0] base_len;
    logic [63:0] base_hex;
    logic [30:0] base_dec;
    t_flags      base_flags;

    // State after this byte is added as content.
    logic [10:0] ac_len;
    logic [63:0] ac_hex;
    logic [30:0] ac_dec;
    t_flags      ac_flags;
    logic [34:0] dec_sum;

    // State of the token being finished.
    logic [10:0]      f_len;
    logic [63:0]      f_hex;
    logic [30:0]      f_dec;
    t_flags           f_flags;
    logic [POS_W-1:0] f_start;

    logic             emit, drop;
    logic [CNT_W-1:0] count_after;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    assign c_nul   = (i_char_in == CH_NUL);
    assign c_quote = is_quote(i_char_in);
    assign c_delim = is_delim(i_char_in);
    assign end_in  = i_last || (r_pos >= POS_LAST);
    assign is_end  = end_in || c_nul;

    // Decide what this byte does to the current token.
    always_comb begin
        do_add         = 1'b0;
        do_begin_quote = 1'b0;
        do_finish      = 1'b0;
        fin_added      = 1'b0;
        if (c_nul) begin
            do_finish = (r_mode == SCAN_WORD);
        end else begin
            unique case (r_mode)
                SCAN_IDLE: begin
                    if (c_quote) begin
                        do_begin_quote = 1'b1;
                    end else if (!c_delim) begin
                        do_add    = 1'b1;
                        do_finish = end_in;
                        fin_added = 1'b1;
                    end
                end
                SCAN_WORD: begin
                    if (c_delim) begin
                        do_finish = 1'b1;
                    end else begin
                        do_add    = 1'b1;
                        do_finish = end_in;
                        fin_added = 1'b1;
                    end
                end
                SCAN_QUOTED: begin
                    if (c_quote) begin
                        do_finish = 1'b1;
                    end else begin
                        do_add = 1'b1;
                    end
                end
                default: begin
                    do_add = 1'b0;
                end
            endcase
        end
    end

    // Next scanner mode.
    always_comb begin
        n_mode = r_mode;
        if (is_end) begin
            n_mode = SCAN_IDLE;
        end else begin
            unique case (r_mode)
                SCAN_IDLE: begin
                    if (c_quote) begin
                        n_mode = SCAN_QUOTED;
                    end else if (!c_delim) begin
                        n_mode = SCAN_WORD;
                    end
                end
                SCAN_WORD: begin
                    if (c_delim) begin
                        n_mode = SCAN_IDLE;
                    end
                end
                SCAN_QUOTED: begin
                    if (c_quote) begin
                        n_mode = SCAN_IDLE;
                    end
                end
                default: begin
                    n_mode = SCAN_IDLE;
                end
            endcase
        end
    end

    // Pick the accumulator base.
    always_comb begin
        if (r_mode == SCAN_IDLE) begin
            base_len   = '0;
            base_hex   = '0;
            base_dec   = '0;
            base_flags = '{digits: 1'b1, default: 1'b0};
        end else begin
            base_len   = r_len;
            base_hex   = r_hex;
            base_dec   = r_dec;
            base_flags = r_flags;
        end
    end

    // Add the byte as content: class flags, hex shift and decimal shift-add.
    assign dec_sum = {1'b0, base_dec, 3'b000} + {3'b000, base_dec, 1'b0} +
                     {27'd0, i_char_in - CH_ZERO};

    always_comb begin
        ac_flags        = base_flags;
        ac_hex          = base_hex;
        ac_dec          = base_dec;
        ac_flags.digits = base_flags.digits && is_digit(i_char_in);
        if ((base_len == 11'd0) && (i_char_in == CH_ZERO)) begin
            ac_flags.zero0 = 1'b1;
        end
        if (base_len == 11'd1) begin
            if ((i_char_in == CH_LX) || (i_char_in == CH_UX)) begin
                ac_flags.x1 = 1'b1;
            end
            ac_flags.hrun = 1'b1;
        end else if ((base_len >= 11'd2) && base_flags.hrun) begin
            if (!is_hex(i_char_in)) begin
                ac_flags.hrun = 1'b0;
            end else if (base_hex[63:60] != 4'h0) begin
                ac_hex        = '1;
                ac_flags.hsat = 1'b1;
            end else begin
                ac_hex = {base_hex[59:0], hex_val(i_char_in)};
            end
        end
        if (ac_flags.digits) begin
            if (dec_sum > {4'd0, DEC_MAX}) begin
                ac_dec        = DEC_MAX;
                ac_flags.dsat = 1'b1;
            end else begin
                ac_dec = dec_sum[30:0];
            end
        end
        ac_len = (base_len != LEN_MAX) ? base_len + 11'd1 : base_len;
    end

    // Finished token and record assembly.
    always_comb begin
        f_len       = fin_added ? ac_len   : r_len;
        f_hex       = fin_added ? ac_hex   : r_hex;
        f_dec       = fin_added ? ac_dec   : r_dec;
        f_flags     = fin_added ? ac_flags : r_flags;
        f_start     = (r_mode == SCAN_IDLE) ? r_pos : r_start;
        emit        = do_finish && (r_count < CNT_MAX);
        drop        = do_finish && !emit;
        count_after = r_count + CNT_W'(emit);

        o_rec           = '0;
        o_rec.tok_valid = emit;
        o_rec.start     = 10'(f_start);
        o_rec.len       = f_len;
        o_rec.index     = 5'(r_count);
        if ((f_len > 11'd2) && f_flags.zero0 && f_flags.x1) begin
            o_rec.kind  = KIND_HEX;
            o_rec.value = f_hex;
            o_rec.sat   = f_flags.hsat;
        end else if (f_flags.digits) begin
            o_rec.kind  = KIND_DEC;
            o_rec.value = {33'd0, f_dec};
            o_rec.sat   = f_flags.dsat;
        end else begin
            o_rec.kind  = KIND_STRING;
        end
        o_rec.eol_valid = is_end;
        o_rec.eol_count = 5'(count_after);
        o_rec.too_many  = r_dropped || drop;
    end

    assign o_push = accept && (emit || is_end);

    // Control state: mode, position, count and the dropped bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= SCAN_IDLE;
            r_pos     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            if (is_end) begin
                r_pos     <= '0;
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else begin
                r_pos     <= r_pos + POS_W'(1);
                r_count   <= count_after;
                r_dropped <= r_dropped || drop;
            end
        end
    end

    // Token accumulators; only meaningful while a token is open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (accept && !is_end) begin
            if (do_begin_quote) begin
                r_start <= r_pos + POS_W'(1);
                r_len   <= '0;
                r_hex   <= '0;
                r_dec   <= '0;
                r_flags <= '{digits: 1'b1, default: 1'b0};
            end else if (do_add) begin
                if (r_mode == SCAN_IDLE) begin
                    r_start <= r_pos;
                end
                r_len   <= ac_len;
                r_hex   <= ac_hex;
                r_dec   <= ac_dec;
                r_flags <= ac_flags;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// Short register queue of scan records between the scanner and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clt_pkg::t_step_rec  i_rec,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output clt_pkg::t_step_rec  o_head
);
    import clt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_step_rec        r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;
    logic             do_pop;

    assign o_full  = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_fill <= r_fill - CNT_W'(1);
            end
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// Output stage: unpacks each record into a token word and/or an end word
// and holds them in the output register until the sink takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  clt_pkg::t_step_rec  i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic [63:0]         o_value,
    output logic [9:0]          o_start_offset,
    output logic [10:0]         o_token_length,
    output logic [4:0]          o_token_index,
    output logic                o_saturated,
    output logic                o_too_many,
    output logic                o_line_end
);
    import clt_pkg::*;

    logic        r_valid;
    logic        r_phase, n_phase;
    logic [1:0]  r_kind;
    logic [63:0] r_value;
    logic [9:0]  r_start;
    logic [10:0] r_len;
    logic [4:0]  r_index;
    logic        r_sat;
    logic        r_too_many;
    logic        r_line_end;

    logic load, take, emit_tok;

    // The output register is free when empty or being taken.
    assign load     = !r_valid || !i_stall;
    assign take     = load && !i_empty;
    assign emit_tok = !r_phase && i_head.tok_valid;

    // A record with both a token and an end marker stays for a second word.
    always_comb begin
        o_pop   = 1'b0;
        n_phase = r_phase;
        if (take) begin
            if (emit_tok && i_head.eol_valid) begin
                n_phase = 1'b1;
            end else begin
                o_pop   = 1'b1;
                n_phase = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= take;
            end
            r_phase <= n_phase;
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (emit_tok) begin
                r_kind     <= i_head.kind;
                r_value    <= i_head.value;
                r_start    <= i_head.start;
                r_len      <= i_head.len;
                r_index    <= i_head.index;
                r_sat      <= i_head.sat;
                r_too_many <= 1'b0;
                r_line_end <= 1'b0;
            end else begin
                r_kind     <= KIND_EOL;
                r_value    <= '0;
                r_start    <= '0;
                r_len      <= '0;
                r_index    <= i_head.eol_count;
                r_sat      <= 1'b0;
                r_too_many <= i_head.too_many;
                r_line_end <= 1'b1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_value        = r_value;
    assign o_start_offset = r_start;
    assign o_token_length = r_len;
    assign o_token_index  = r_index;
    assign o_saturated    = r_sat;
    assign o_too_many     = r_too_many;
    assign o_line_end     = r_line_end;

endmodule

`default_nettype wire

FILE: rtl/command_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// Command line tokenizer: bytes in, classified tokens and end markers out.
//
//   Channel  Direction  Handshake           Word
//   input    in         i_valid / o_stall   i_char_in, i_last
//   output   out        o_valid / i_stall   kind, value, offset, length, index, flags
//
// One byte is taken per cycle while the scanner-to-output queue has room.
// A byte that closes a token and also ends the line gives two output words;
// the output stage keeps that record at the queue head until both words are loaded.
// An accepted byte's first word passes through the queue slot and then the output register.
// Reset is synchronous; no clearing pass.
// Output stall fills the four-entry queue, after which o_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_tokenizer_top #(
    parameter int MAX_TOKENS = clt_pkg::MAX_TOKENS_DEF,
    parameter int MAX_LINE   = clt_pkg::MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [63:0] o_value,
    output logic [9:0]  o_start_offset,
    output logic [10:0] o_token_length,
    output logic [4:0]  o_token_index,
    output logic        o_saturated,
    output logic        o_too_many,
    output logic        o_line_end
);
    import clt_pkg::*;

    t_step_rec push_rec;
    t_step_rec head_rec;
    logic      push, pop, full, empty;

    // Scanner.
    clt_front #(
        .MAX_TOKENS (MAX_TOKENS),
        .MAX_LINE   (MAX_LINE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_char_in (i_char_in),
        .i_last    (i_last),
        .o_stall   (o_stall),
        .i_full    (full),
        .o_push    (push),
        .o_rec     (push_rec)
    );

    // Record queue.
    clt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_rec)
    );

    // Output stage.
    clt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head_rec),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_value        (o_value),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_token_index  (o_token_index),
        .o_saturated    (o_saturated),
        .o_too_many     (o_too_many),
        .o_line_end     (o_line_end)
    );

endmodule

`default_nettype wire

FILE: rtl/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the tokenizer's output words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_char_in,
    input wire logic        i_last,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [63:0] o_value,
    input wire logic [9:0]  o_start_offset,
    input wire logic [10:0] o_token_length,
    input wire logic [4:0]  o_token_index,
    input wire logic        o_saturated,
    input wire logic        o_too_many,
    input wire logic        o_line_end
);
    import clt_pkg::*;

    logic [94:0] out_word;
    logic [8:0]  in_word;
    logic        plain_word;

    // Whole words on each channel, and output words that carry no number.
    assign out_word   = {o_kind, o_value, o_start_offset, o_token_length, o_token_index,
                         o_saturated, o_too_many, o_line_end};
    assign in_word    = {i_char_in, i_last};
    assign plain_word = o_valid && ((o_kind == KIND_STRING) || (o_kind == KIND_EOL));

    // A stalled output word stays in place.
    `CLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))

    // A stalled input word stays in place.
    `CLT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(in_word))

    // The end flag marks exactly the end-of-line words.
    `CLT_ASSERT_NOW(a_end_kind, i_clk, i_rst_n, o_valid, o_line_end == (o_kind == KIND_EOL))

    // The overflow flag only appears on an end word.
    `CLT_ASSERT_NOW(a_too_many_end, i_clk, i_rst_n, o_valid && o_too_many, o_line_end)

    // Strings and end words carry no number.
    `CLT_ASSERT_NOW(a_no_number, i_clk, i_rst_n, plain_word, o_value == 64'd0 && !o_saturated)

endmodule

bind command_line_tokenizer_top clt_checker u_clt_checker (.*);

`default_nettype wire
